// ===== sv/bsm_pkg.sv =====
`timescale 1ns / 1ps

package bsm_pkg;

    localparam int PRG_BANK_BITS = 6;
    localparam int CHR_BANK_BITS = 8;
    localparam int OFFSET_BITS   = 19;
    localparam int COUNT_BITS    = 7;
    localparam int PRG_SLOTS     = 4;
    localparam int CHR_SLOTS     = 8;

    localparam logic [COUNT_BITS-1:0] PRG_COUNT_RESET = 7'd32;
    localparam logic [7:0]            IRQ_RESET       = 8'd255;

    // configuration register indexes
    localparam logic REG_PRG_BANK_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_PRG   = 2'd2,
        ACT_CHR   = 2'd3
    } action_t;

    // CPU register window, addr[14:13]
    typedef enum logic [1:0] {
        WIN_BANK   = 2'd0,
        WIN_MIRROR = 2'd1,
        WIN_LATCH  = 2'd2,
        WIN_ENABLE = 2'd3
    } window_t;

    // bank-select commands
    localparam logic [2:0] CMD_CHR_PAIR0 = 3'd0;
    localparam logic [2:0] CMD_CHR_PAIR1 = 3'd1;
    localparam logic [2:0] CMD_CHR_4     = 3'd2;
    localparam logic [2:0] CMD_CHR_5     = 3'd3;
    localparam logic [2:0] CMD_CHR_6     = 3'd4;
    localparam logic [2:0] CMD_CHR_7     = 3'd5;
    localparam logic [2:0] CMD_PRG_FIRST = 3'd6;
    localparam logic [2:0] CMD_PRG_SECOND = 3'd7;

    typedef logic [PRG_BANK_BITS-1:0] prg_bank_t;
    typedef logic [CHR_BANK_BITS-1:0] chr_bank_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] addr;
        logic [7:0]  value;
    } req_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] rom_offset;
        logic                   irq_pulse;
        logic                   mirror_horizontal;
    } rsp_t;

    // count minus k, wrapped to the bank width
    function automatic prg_bank_t count_minus(input logic [COUNT_BITS-1:0] count,
                                              input logic [1:0] k);
        logic [31:0] diff;
        diff = 32'(count) - 32'(k);
        return diff[PRG_BANK_BITS-1:0];
    endfunction

endpackage

// ===== sv/bank_select_mapper_with_scanline_irq_core.sv =====
`timescale 1ns / 1ps

// MMC3-style bank-select mapper with scanline IRQ counter. Each request is a
// CPU register write, a scanline tick, a PRG address or a CHR address; each
// gives exactly one response with the ROM offset, IRQ pulse and mirroring mode.
// A request is registered on transfer, resolved combinationally against the
// mapper state and placed in the response register; one request is taken per
// cycle while responses are taken, and a waiting response still lets the next
// request in. prg_bank_count (byte address 0) takes effect at the next R6/R7
// write; the user must write it only while the block is idle (not enforced).
module bank_select_mapper_with_scanline_irq_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bsm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bsm_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic                            req_valid_reg;
    bsm_pkg::req_t                   req_reg;
    logic                            rsp_valid_reg;
    bsm_pkg::rsp_t                   rsp_reg;
    logic [bsm_pkg::COUNT_BITS-1:0]  prg_count_reg;
    bsm_pkg::rsp_t                   rsp_next;
    logic                            advance;
    logic                            reg_sel;

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == bsm_pkg::REG_PRG_BANK_COUNT) && (paddr[1:0] == 2'b00);
    assign prdata    = reg_sel ? 32'(prg_count_reg) : 32'd0;

    bsm_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .req            (req_reg),
        .prg_bank_count (prg_count_reg),
        .rsp            (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            prg_count_reg <= bsm_pkg::PRG_COUNT_RESET;
        end
        else
        begin
            if (req_ready)
                req_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (psel && penable && pwrite && reg_sel)
                prg_count_reg <= pwdata[bsm_pkg::COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        if (advance)
            rsp_reg <= rsp_next;
    end

endmodule

// ===== sv/bsm_engine.sv =====
`timescale 1ns / 1ps

module bsm_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  bsm_pkg::req_t                        req,
    input  logic [bsm_pkg::COUNT_BITS-1:0]       prg_bank_count,
    output bsm_pkg::rsp_t                        rsp
);

    logic [2:0]          select_command_reg, select_command_next;
    logic                prg_mode_reg, prg_mode_next;
    logic                chr_invert_reg, chr_invert_next;
    bsm_pkg::prg_bank_t  prg_first_reg, prg_first_next;
    bsm_pkg::prg_bank_t  prg_second_reg, prg_second_next;
    bsm_pkg::prg_bank_t  prg_slot_reg [bsm_pkg::PRG_SLOTS];
    bsm_pkg::prg_bank_t  prg_slot_next [bsm_pkg::PRG_SLOTS];
    bsm_pkg::chr_bank_t  chr_slot_reg [bsm_pkg::CHR_SLOTS];
    bsm_pkg::chr_bank_t  chr_slot_next [bsm_pkg::CHR_SLOTS];
    logic                mirror_reg, mirror_next;
    logic [7:0]          irq_count_reg, irq_count_next;
    logic [7:0]          irq_reload_reg, irq_reload_next;
    logic                irq_on_reg, irq_on_next;

    bsm_pkg::prg_bank_t  mask;
    bsm_pkg::prg_bank_t  second_last;
    bsm_pkg::prg_bank_t  last;
    logic                odd;
    logic                remap;
    logic [2:0]          flip;
    logic [31:0]         prg_off;
    logic [31:0]         chr_off;

    assign mask        = bsm_pkg::count_minus(prg_bank_count, 2'd1);
    assign second_last = bsm_pkg::count_minus(prg_bank_count, 2'd2);
    assign last        = mask;
    assign odd         = req.addr[0];
    assign flip        = {chr_invert_reg, 2'b00};

    always_comb
    begin
        select_command_next = select_command_reg;
        prg_mode_next       = prg_mode_reg;
        chr_invert_next     = chr_invert_reg;
        prg_first_next      = prg_first_reg;
        prg_second_next     = prg_second_reg;
        prg_slot_next       = prg_slot_reg;
        chr_slot_next       = chr_slot_reg;
        mirror_next         = mirror_reg;
        irq_count_next      = irq_count_reg;
        irq_reload_next     = irq_reload_reg;
        irq_on_next         = irq_on_reg;
        remap               = 1'b0;
        rsp                 = '0;

        unique case (req.action)
            bsm_pkg::ACT_WRITE:
            begin
                if (req.addr[15])
                begin
                    unique case (bsm_pkg::window_t'(req.addr[14:13]))
                        bsm_pkg::WIN_BANK:
                        begin
                            if (!odd)
                            begin
                                select_command_next = req.value[2:0];
                                prg_mode_next       = req.value[6];
                                chr_invert_next     = req.value[7];
                            end
                            else
                            begin
                                unique case (select_command_reg)
                                    bsm_pkg::CMD_CHR_PAIR0:
                                    begin
                                        chr_slot_next[3'd0 ^ flip] =
                                            bsm_pkg::CHR_BANK_BITS'(req.value);
                                        chr_slot_next[3'd1 ^ flip] =
                                            bsm_pkg::CHR_BANK_BITS'(req.value + 8'd1);
                                    end
                                    bsm_pkg::CMD_CHR_PAIR1:
                                    begin
                                        chr_slot_next[3'd2 ^ flip] =
                                            bsm_pkg::CHR_BANK_BITS'(req.value);
                                        chr_slot_next[3'd3 ^ flip] =
                                            bsm_pkg::CHR_BANK_BITS'(req.value + 8'd1);
                                    end
                                    bsm_pkg::CMD_CHR_4:
                                        chr_slot_next[3'd4 ^ flip] =
                                            bsm_pkg::CHR_BANK_BITS'(req.value);
                                    bsm_pkg::CMD_CHR_5:
                                        chr_slot_next[3'd5 ^ flip] =
                                            bsm_pkg::CHR_BANK_BITS'(req.value);
                                    bsm_pkg::CMD_CHR_6:
                                        chr_slot_next[3'd6 ^ flip] =
                                            bsm_pkg::CHR_BANK_BITS'(req.value);
                                    bsm_pkg::CMD_CHR_7:
                                        chr_slot_next[3'd7 ^ flip] =
                                            bsm_pkg::CHR_BANK_BITS'(req.value);
                                    bsm_pkg::CMD_PRG_FIRST:
                                    begin
                                        prg_first_next =
                                            bsm_pkg::PRG_BANK_BITS'(32'(req.value)) & mask;
                                        remap = 1'b1;
                                    end
                                    default:
                                    begin
                                        prg_second_next =
                                            bsm_pkg::PRG_BANK_BITS'(32'(req.value)) & mask;
                                        remap = 1'b1;
                                    end
                                endcase
                            end
                        end
                        bsm_pkg::WIN_MIRROR:
                        begin
                            if (!odd)
                                mirror_next = req.value[0];
                        end
                        bsm_pkg::WIN_LATCH:
                        begin
                            if (odd)
                                irq_count_next = 8'd0;
                            else
                                irq_reload_next = req.value;
                        end
                        default:
                            irq_on_next = odd;
                    endcase
                end
            end
            bsm_pkg::ACT_TICK:
            begin
                if (irq_count_reg != 8'd0)
                    irq_count_next = irq_count_reg - 8'd1;
                else
                begin
                    rsp.irq_pulse  = irq_on_reg;
                    irq_count_next = irq_reload_reg;
                end
            end
            bsm_pkg::ACT_PRG:
                rsp.rom_offset = prg_off[bsm_pkg::OFFSET_BITS-1:0];
            default:
                rsp.rom_offset = chr_off[bsm_pkg::OFFSET_BITS-1:0];
        endcase

        if (remap)
        begin
            if (prg_mode_reg)
            begin
                prg_slot_next[0] = second_last;
                prg_slot_next[1] = prg_second_next;
                prg_slot_next[2] = prg_first_next;
            end
            else
            begin
                prg_slot_next[0] = prg_first_next;
                prg_slot_next[1] = prg_second_next;
                prg_slot_next[2] = second_last;
            end
            prg_slot_next[3] = last;
        end

        rsp.mirror_horizontal = mirror_next;
    end

    assign prg_off = (32'(prg_slot_reg[req.addr[14:13]]) << 13) | 32'(req.addr[12:0]);
    assign chr_off = (32'(chr_slot_reg[req.addr[12:10]]) << 10) | 32'(req.addr[9:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_command_reg <= '0;
            prg_mode_reg       <= 1'b0;
            chr_invert_reg     <= 1'b0;
            prg_first_reg      <= '0;
            prg_second_reg     <= '0;
            prg_slot_reg[0]    <= '0;
            prg_slot_reg[1]    <= bsm_pkg::PRG_BANK_BITS'(32'd1);
            prg_slot_reg[2]    <= bsm_pkg::count_minus(bsm_pkg::PRG_COUNT_RESET, 2'd2);
            prg_slot_reg[3]    <= bsm_pkg::count_minus(bsm_pkg::PRG_COUNT_RESET, 2'd1);
            for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++)
                chr_slot_reg[i] <= bsm_pkg::CHR_BANK_BITS'(i);
            mirror_reg         <= 1'b0;
            irq_count_reg      <= bsm_pkg::IRQ_RESET;
            irq_reload_reg     <= bsm_pkg::IRQ_RESET;
            irq_on_reg         <= 1'b0;
        end
        else if (step)
        begin
            select_command_reg <= select_command_next;
            prg_mode_reg       <= prg_mode_next;
            chr_invert_reg     <= chr_invert_next;
            prg_first_reg      <= prg_first_next;
            prg_second_reg     <= prg_second_next;
            prg_slot_reg       <= prg_slot_next;
            chr_slot_reg       <= chr_slot_next;
            mirror_reg         <= mirror_next;
            irq_count_reg      <= irq_count_next;
            irq_reload_reg     <= irq_reload_next;
            irq_on_reg         <= irq_on_next;
        end
    end

endmodule
